>>> hw/rtl/bsa_pkg.sv
// Shared types and constants of the bitmap slot allocator.
package bsa_pkg;

  localparam int CNT_W     = 13;         // slot counts and the slot-total register
  localparam int IDX_W     = 12;         // slot numbers on the ports
  localparam int SLOT_W    = CNT_W + 1;  // internal slot positions, room for a sum
  localparam int TOT_RESET = 4096;       // slot total after reset

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BOUNDS  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    req_kind_t              req_type;
    logic [IDX_W-1:0]       start_slot;
    logic [CNT_W-1:0]       slot_count;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [IDX_W-1:0]       run_start;
    logic [CNT_W-1:0]       free_count;
    logic [CNT_W-1:0]       skipped_count;
  } rsp_t;

  // Result of scanning one map word for a free run.
  typedef struct packed {
    logic hit;         // the run completes inside this word
    logic hit_fresh;   // the completed run started inside this word
    logic tail_fresh;  // the run leaving this word started inside it
  } scan_flags_t;

endpackage

>>> hw/rtl/bsa_map_ram.sv
// Used-bit map memory with per-word valid bits and a registered read port.
module bsa_map_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clr,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;

  // A word that was never written since the last clear reads as all free.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= vld[rd_addr] ? mem[rd_addr] : '0;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

endmodule

>>> hw/rtl/bsa_scan_unit.sv
// Free-run search over one map word, continuing a run carried in from lower words.
module bsa_scan_unit #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]          word,
  input  logic [bsa_pkg::SLOT_W-1:0]    base,
  input  logic [bsa_pkg::CNT_W-1:0]     total,
  input  logic [bsa_pkg::SLOT_W-1:0]    carry,
  input  logic [bsa_pkg::CNT_W-1:0]     count,
  output bsa_pkg::scan_flags_t          flags,
  output logic [$clog2(WORD_BITS)-1:0]  hit_pos,
  output logic [bsa_pkg::SLOT_W-1:0]    carry_out
);
  import bsa_pkg::*;

  localparam int PW  = $clog2(WORD_BITS);
  localparam int LVL = PW;

  logic [SLOT_W-1:0]    room;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] used;
  logic [WORD_BITS-1:0] hit_vec;
  logic                 has_l [LVL+1][WORD_BITS];
  logic [PW-1:0]        pos_l [LVL+1][WORD_BITS];
  logic [SLOT_W-1:0]    run   [WORD_BITS];

  // Slots at or past the total count as used so no run reaches them.
  always_comb begin
    if (SLOT_W'(total) > base) begin
      room = SLOT_W'(total) - base;
    end else begin
      room = '0;
    end
    if (room >= SLOT_W'(WORD_BITS)) begin
      lim_mask = '1;
    end else begin
      lim_mask = ~({WORD_BITS{1'b1}} << room[PW-1:0]);
    end
    used = word | ~lim_mask;
  end

  // Log-depth prefix: for every bit, the highest used bit at or below it.
  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      has_l[0][p] = used[p];
      pos_l[0][p] = PW'(p);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int p = 0; p < WORD_BITS; p++) begin
        if ((p >= (1 << l)) && !has_l[l][p]) begin
          has_l[l+1][p] = has_l[l][p - (1 << l)];
          pos_l[l+1][p] = pos_l[l][p - (1 << l)];
        end else begin
          has_l[l+1][p] = has_l[l][p];
          pos_l[l+1][p] = pos_l[l][p];
        end
      end
    end
  end

  // Run length ending at each bit, and the lowest bit where it reaches the request.
  always_comb begin
    for (int p = 0; p < WORD_BITS; p++) begin
      if (has_l[LVL][p]) begin
        run[p] = SLOT_W'(PW'(p) - pos_l[LVL][p]);
      end else begin
        run[p] = carry + SLOT_W'(p + 1);
      end
      hit_vec[p] = !used[p] && (run[p] >= SLOT_W'(count));
    end
    hit_pos         = '0;
    flags.hit_fresh = 1'b0;
    for (int p = WORD_BITS - 1; p >= 0; p--) begin
      if (hit_vec[p]) begin
        hit_pos         = PW'(p);
        flags.hit_fresh = has_l[LVL][p];
      end
    end
    flags.hit        = |hit_vec;
    flags.tail_fresh = has_l[LVL][WORD_BITS-1];
    carry_out        = run[WORD_BITS-1];
  end

endmodule

>>> hw/rtl/bsa_word_update.sv
// Read-modify-write of one map word over a slot range, with a count of used bits hit.
module bsa_word_update #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]             old_word,
  input  logic [bsa_pkg::SLOT_W-1:0]       base,
  input  logic [bsa_pkg::SLOT_W-1:0]       lo,
  input  logic [bsa_pkg::SLOT_W-1:0]       hi,
  input  logic                             set_op,
  output logic [WORD_BITS-1:0]             new_word,
  output logic [$clog2(WORD_BITS+1)-1:0]   pop,
  output logic                             last
);
  import bsa_pkg::*;

  localparam int PW  = $clog2(WORD_BITS);
  localparam int PCW = $clog2(WORD_BITS + 1);

  logic [SLOT_W-1:0]    lo_rel;
  logic [SLOT_W-1:0]    hi_rel;
  logic [WORD_BITS-1:0] range_mask;

  function automatic logic [WORD_BITS-1:0] low_mask(input logic [SLOT_W-1:0] rel);
    logic [WORD_BITS-1:0] m;
    if (rel >= SLOT_W'(WORD_BITS)) begin
      m = '1;
    end else begin
      m = ~({WORD_BITS{1'b1}} << rel[PW-1:0]);
    end
    return m;
  endfunction

  always_comb begin
    lo_rel     = (lo > base) ? (lo - base) : '0;
    hi_rel     = (hi > base) ? (hi - base) : '0;
    range_mask = low_mask(hi_rel) & ~low_mask(lo_rel);
    new_word   = set_op ? (old_word | range_mask) : (old_word & ~range_mask);
    pop        = PCW'($countones(old_word & range_mask));
    last       = (base + SLOT_W'(WORD_BITS)) >= hi;
  end

endmodule

>>> hw/rtl/bitmap_slot_allocator.sv
// Top level of the bitmap slot allocator: sequencer, counters and map memory.
//
//   channel   ports                    direction  transfer when
//   request   start, busy, req         in         start high and busy low at the edge
//   result    done, rsp                out        every cycle done is high (no stall)
//   config    cfg_we, cfg_wdata        in         cfg_we high at the edge
//
// An allocate scans the used-bit map one word per cycle through a single shared
// scan unit, then sweeps the words of the found run through the word update unit,
// one read-modify-write per cycle on the map memory's single read and write port.
// While busy, an allocate scans words until it finds a run and then sweeps the words
// spanned by the run; one that finds no run stops after the last word that holds
// slots below the slot total. A free sweeps every word up to the one that holds the
// range end, since the sweep starts at word zero. A zero count, an oversize allocate
// and an out-of-range free go straight to the result. Each result shows for one cycle with done high;
// the receiver cannot stall, so busy falls in the cycle after done.
// Reset and every write of the slot total clear the map through the
// per-word valid bits; there is no clearing pass.
module bitmap_slot_allocator #(
  parameter int MAX_SLOTS = 4096,
  parameter int WORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  bsa_pkg::req_t               req,
  output logic                        done,
  output bsa_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic [bsa_pkg::CNT_W-1:0]   cfg_wdata
);
  import bsa_pkg::*;

  localparam int NUM_WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PW        = $clog2(WORD_BITS);
  localparam int PCW       = $clog2(WORD_BITS + 1);
  localparam int CAP_I     = (MAX_SLOTS > (2 ** CNT_W) - 1) ? (2 ** CNT_W) - 1 : MAX_SLOTS;
  localparam int RST_I     = (TOT_RESET > CAP_I) ? CAP_I : TOT_RESET;
  localparam logic [CNT_W-1:0]  TOT_CAP  = CAP_I[CNT_W-1:0];
  localparam logic [CNT_W-1:0]  TOT_RST  = RST_I[CNT_W-1:0];
  localparam logic [SLOT_W-1:0] WORD_INC = SLOT_W'(WORD_BITS);

  // Sequencer and counters that reset clears.
  seq_state_t           state;
  seq_state_t           state_next;
  logic                 pend;
  logic [CNT_W-1:0]     tot;
  logic [CNT_W-1:0]     free_ctr;

  // Request and datapath registers.
  req_t                 req_q;
  status_t              status;
  logic [AW-1:0]        iss_addr;
  logic [SLOT_W-1:0]    iss_base;
  logic [AW-1:0]        pend_addr;
  logic [SLOT_W-1:0]    pend_base;
  logic [SLOT_W-1:0]    carry;
  logic [AW-1:0]        run_addr;
  logic [SLOT_W-1:0]    run_base;
  logic [SLOT_W-1:0]    lo;
  logic [SLOT_W-1:0]    hi;
  logic [CNT_W-1:0]     acc;

  // Memory and shared units.
  logic                 rd_en;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  scan_flags_t          sflags;
  logic [PW-1:0]        hit_pos;
  logic [SLOT_W-1:0]    carry_out;
  logic [PCW-1:0]       pop;
  logic                 upd_last;

  logic                 accept;
  logic                 scan_last;
  logic                 scan_hit;
  logic [SLOT_W-1:0]    req_end;
  logic [SLOT_W-1:0]    hit_start;
  logic [CNT_W-1:0]     cfg_sat;

  assign accept    = start && !busy;
  assign scan_last = (pend_base + WORD_INC) >= SLOT_W'(tot);
  assign scan_hit  = (state == S_SCAN) && pend && sflags.hit;
  assign req_end   = SLOT_W'(req.start_slot) + SLOT_W'(req.slot_count);
  assign hit_start = pend_base + SLOT_W'(hit_pos) + SLOT_W'(1) - SLOT_W'(req_q.slot_count);

  // A written total of zero means one slot; anything above the map size is capped.
  always_comb begin
    if (cfg_wdata == '0) begin
      cfg_sat = CNT_W'(1);
    end else if (cfg_wdata > TOT_CAP) begin
      cfg_sat = TOT_CAP;
    end else begin
      cfg_sat = cfg_wdata;
    end
  end

  bsa_map_ram #(
    .DEPTH (NUM_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_map (
    .clk     (clk),
    .rst     (rst),
    .clr     (cfg_we),
    .rd_en   (rd_en),
    .rd_addr (iss_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bsa_scan_unit #(
    .WORD_BITS (WORD_BITS)
  ) u_scan (
    .word      (rd_data),
    .base      (pend_base),
    .total     (tot),
    .carry     (carry),
    .count     (req_q.slot_count),
    .flags     (sflags),
    .hit_pos   (hit_pos),
    .carry_out (carry_out)
  );

  bsa_word_update #(
    .WORD_BITS (WORD_BITS)
  ) u_upd (
    .old_word (rd_data),
    .base     (pend_base),
    .lo       (lo),
    .hi       (hi),
    .set_op   (req_q.req_type == REQ_ALLOC),
    .new_word (wr_data),
    .pop      (pop),
    .last     (upd_last)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.slot_count == '0) begin
            state_next = S_RESP;
          end else if (req.req_type == REQ_ALLOC) begin
            state_next = (req.slot_count > tot) ? S_RESP : S_SCAN;
          end else begin
            state_next = (req_end > SLOT_W'(tot)) ? S_RESP : S_APPLY;
          end
        end
      end
      S_SCAN: begin
        if (pend) begin
          if (sflags.hit) begin
            state_next = S_APPLY;
          end else if (scan_last) begin
            state_next = S_RESP;
          end
        end
      end
      S_APPLY: begin
        if (pend && upd_last) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer: memory port control and the result.
  always_comb begin
    busy    = (state != S_IDLE);
    done    = (state == S_RESP);
    rd_en   = ((state == S_SCAN) && (iss_base < SLOT_W'(tot))) ||
              ((state == S_APPLY) && (iss_base < hi));
    wr_en   = (state == S_APPLY) && pend;
    wr_addr = pend_addr;
    rsp.status        = status;
    rsp.free_count    = free_ctr;
    rsp.run_start     = '0;
    rsp.skipped_count = '0;
    if (status == ST_OK) begin
      if (req_q.req_type == REQ_ALLOC) begin
        rsp.run_start = lo[IDX_W-1:0];
      end else begin
        rsp.skipped_count = req_q.slot_count - acc;
      end
    end
  end

  // Control registers: state, read pipeline flag, slot total and free counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pend     <= 1'b0;
      tot      <= TOT_RST;
      free_ctr <= TOT_RST;
    end else begin
      state <= state_next;
      pend  <= rd_en && !scan_hit;
      if (cfg_we) begin
        tot      <= cfg_sat;
        free_ctr <= cfg_sat;
      end else if (scan_hit) begin
        free_ctr <= free_ctr - req_q.slot_count;
      end else if ((state == S_APPLY) && pend && (req_q.req_type == REQ_FREE)) begin
        free_ctr <= free_ctr + CNT_W'(pop);
      end
    end
  end

  // Datapath registers. Reads are issued one word per cycle; the word comes back
  // from the registered read port and is handled with the address and base recorded at issue.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_addr <= iss_addr;
      pend_base <= iss_base;
    end
    // On a scan hit the issue pointer jumps back to the start of the run instead.
    if (rd_en && !scan_hit) begin
      iss_addr  <= iss_addr + AW'(1);
      iss_base  <= iss_base + WORD_INC;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          req_q    <= req;
          iss_addr <= '0;
          iss_base <= '0;
          carry    <= '0;
          run_addr <= '0;
          run_base <= '0;
          acc      <= '0;
          lo       <= SLOT_W'(req.start_slot);
          hi       <= req_end;
          if (req.slot_count == '0) begin
            status <= ST_ZERO;
          end else if (req.req_type == REQ_ALLOC) begin
            status <= (req.slot_count > tot) ? ST_NOSPACE : ST_OK;
          end else begin
            status <= (req_end > SLOT_W'(tot)) ? ST_BOUNDS : ST_OK;
          end
        end
      end
      S_SCAN: begin
        if (pend) begin
          if (sflags.hit) begin
            // The run is marked starting at the word that holds its first slot.
            lo <= hit_start;
            hi <= hit_start + SLOT_W'(req_q.slot_count);
            if (sflags.hit_fresh) begin
              iss_addr <= pend_addr;
              iss_base <= pend_base;
            end else begin
              iss_addr <= run_addr;
              iss_base <= run_base;
            end
          end else if (scan_last) begin
            status <= ST_NOSPACE;
          end else begin
            carry <= carry_out;
            if (carry_out == '0) begin
              run_addr <= pend_addr + AW'(1);
              run_base <= pend_base + WORD_INC;
            end else if (sflags.tail_fresh) begin
              run_addr <= pend_addr;
              run_base <= pend_base;
            end
          end
        end
      end
      S_APPLY: begin
        if (pend && (req_q.req_type == REQ_FREE)) begin
          acc <= acc + CNT_W'(pop);
        end
      end
      S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  // The free counter can never pass the slot total.
  a_free_le_total: assert property (@(posedge clk) disable iff (rst)
    free_ctr <= tot)
    else $error("free counter above slot total");

  // The read-modify-write sweep never reads the word it is writing.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != iss_addr))
    else $error("map read and write to the same word");

  // A successful allocation lies wholly below the slot total.
  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_OK) && (req_q.req_type == REQ_ALLOC)) |->
      (hi <= SLOT_W'(tot)))
    else $error("allocated run past slot total");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("request accepted without going busy");

  // A result is shown for one cycle only.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the bitmap slot allocator: directed and random requests.
`timescale 1ns / 100ps

module testbench;
  import bsa_pkg::*;

  // Map size of the block under test; also the ceiling of the slot total.
  localparam int MAP_SLOTS = 4096;
  localparam int WORD_SLOTS = 64;
  // Cycles with no transfer on either channel before the run is called hung.
  // The limit lies far above the slowest request and the longest sender gap.
  localparam int STALL_LIMIT = 5000;
  localparam int NUM_PHASES = 9;

  typedef struct {
    int unsigned base;
    int unsigned len;
  } slot_run_t;

  // Tracks the used-bit map, the free count and the slot total, and queues the
  // response that every accepted request must produce, in order.
  class slot_scoreboard;
    bit          used_map [MAP_SLOTS];
    int unsigned total;
    int unsigned free_left;
    rsp_t        pending [$];
    slot_run_t   runs [$];
    int          errors;

    function new();
      errors = 0;
      set_total(CNT_W'(TOT_RESET));
    endfunction

    // A total write clears the map; zero and oversize values are saturated.
    function void set_total(input logic [CNT_W-1:0] value);
      total = value;
      if (total == 0) total = 1;
      if (total > MAP_SLOTS) total = MAP_SLOTS;
      foreach (used_map[i]) used_map[i] = 1'b0;
      free_left = total;
      runs.delete();
    endfunction

    // Called on each request transfer: works out the response and updates the map.
    function void note_request(input req_t r);
      rsp_t        e;
      int unsigned cnt;
      int unsigned first;
      int unsigned base;
      int unsigned run;
      int unsigned skipped;
      bit          found;
      e = '0;
      e.status = ST_OK;
      cnt = r.slot_count;
      first = r.start_slot;
      base = 0;
      skipped = 0;
      found = 1'b0;
      if (cnt == 0) begin
        e.status = ST_ZERO;
      end else if (r.req_type == REQ_ALLOC) begin
        // First fit: the run ends at the lowest slot where cnt free slots in a row
        // have been seen, and it never reaches past the slot total.
        run = 0;
        if (cnt <= total) begin
          for (int unsigned i = 0; i < total && !found; i++) begin
            if (used_map[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == cnt) begin
                base = i + 1 - cnt;
                found = 1'b1;
              end
            end
          end
        end
        if (found) begin
          for (int unsigned i = 0; i < cnt; i++) used_map[base + i] = 1'b1;
          free_left -= cnt;
          e.run_start = IDX_W'(base);
          runs.push_back('{base, cnt});
        end else begin
          e.status = ST_NOSPACE;
        end
      end else begin
        // The bound is taken in 32 bits, so start plus count cannot wrap.
        if (first + cnt > total) begin
          e.status = ST_BOUNDS;
        end else begin
          for (int unsigned i = 0; i < cnt; i++) begin
            if (used_map[first + i]) begin
              used_map[first + i] = 1'b0;
              free_left++;
            end else begin
              skipped++;
            end
          end
        end
      end
      e.free_count = CNT_W'(free_left);
      e.skipped_count = CNT_W'(skipped);
      pending.push_back(e);
    endfunction

    // Called on each result transfer: compares it with the oldest expected response.
    function void check_result(input rsp_t a);
      rsp_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d index %0d free %0d skipped %0d",
                 $time, a.status, a.run_start, a.free_count, a.skipped_count);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d, actual %0d", $time, e.status, a.status);
        errors++;
      end
      if (a.run_start !== e.run_start) begin
        $display("%0t: run_start expected %0d, actual %0d", $time, e.run_start,
                 a.run_start);
        errors++;
      end
      if (a.free_count !== e.free_count) begin
        $display("%0t: free_count expected %0d, actual %0d", $time, e.free_count,
                 a.free_count);
        errors++;
      end
      if (a.skipped_count !== e.skipped_count) begin
        $display("%0t: skipped_count expected %0d, actual %0d", $time, e.skipped_count,
                 a.skipped_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  req_t             req;
  logic             done;
  rsp_t             rsp;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  slot_scoreboard sb = new();

  int stall_cycles = 0;
  int sent = 0;

  // Slot totals visited after the directed part, extremes included: zero and 1
  // give a single slot, 8191 saturates to the full map. Small totals fill up
  // quickly, which is where no-space results and fragmentation show up.
  logic [CNT_W-1:0] phase_total [NUM_PHASES] =
    '{13'd0, 13'd8191, 13'd64, 13'd65, 13'd200, 13'd4096, 13'd1, 13'd1000, 13'd130};
  int phase_items [NUM_PHASES] = '{10, 140, 80, 80, 120, 150, 10, 120, 70};

  bitmap_slot_allocator #(
    .MAX_SLOTS (MAP_SLOTS),
    .WORD_BITS (WORD_SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results cannot be held off, so every cycle with done high is a transfer.
  always @(posedge clk) begin
    if (!rst && done) begin
      sb.check_result(rsp);
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic req_t mk(input req_kind_t kind, input int unsigned first,
                              input int unsigned cnt);
    req_t r;
    r.req_type = kind;
    r.start_slot = IDX_W'(first);
    r.slot_count = CNT_W'(cnt);
    return r;
  endfunction

  // Random request. Most of the mix is allocations and frees of runs that were
  // handed out, so the map fills, fragments and drains; the rest is frees of
  // arbitrary in-range spans, zero counts and fully random fields.
  function automatic req_t pick_item();
    req_t        r;
    int unsigned roll;
    int unsigned k;
    int unsigned span;
    int unsigned cap;
    slot_run_t   run;
    r.req_type = REQ_ALLOC;
    r.start_slot = IDX_W'($urandom());
    r.slot_count = '0;
    roll = $urandom_range(0, 99);
    cap = sb.total;
    if (roll < 45 || (roll < 80 && sb.runs.size() == 0)) begin
      k = $urandom_range(0, 19);
      if (k < 14) span = $urandom_range(1, 12);
      else if (k < 18) span = $urandom_range(1, 140);
      else span = $urandom_range(1, cap);
      r.slot_count = CNT_W'(span);
    end else if (roll < 80) begin
      k = $urandom_range(0, sb.runs.size() - 1);
      run = sb.runs[k];
      sb.runs.delete(k);
      r = mk(REQ_FREE, run.base, run.len);
    end else if (roll < 90) begin
      span = $urandom_range(1, (cap < 16) ? cap : 16);
      r = mk(REQ_FREE, $urandom_range(0, cap - span), span);
    end else if (roll < 95) begin
      r.req_type = req_kind_t'($urandom_range(0, 1));
    end else begin
      r.req_type = req_kind_t'($urandom_range(0, 1));
      r.slot_count = CNT_W'($urandom());
    end
    return r;
  endfunction

  // Presents one request and returns at the edge where it transfers. The caller
  // may present the next one at that same edge without dropping start.
  task automatic send_req(input req_t r);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  // Sender idling: roughly a quarter of requests are preceded by a gap, mostly
  // short, sometimes long enough to cover a whole map scan. A stretch in the
  // middle of the run goes back to back.
  task automatic issue(input req_t r);
    int unsigned gap;
    if ((sent < 350 || sent >= 500) && $urandom_range(0, 99) < 24) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(7, 80);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    send_req(r);
    sent++;
  endtask

  // Waits until every expected result has arrived and busy has dropped.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_total(input logic [CNT_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_total(value);
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part on the full map left by reset: zero counts of both kinds,
    // oversize allocations, the whole map taken at once, a free right at the top
    // slot, an out-of-range free whose end would wrap a narrow adder, runs that
    // cross a word boundary, and a hole that a later allocation refills exactly.
    issue(mk(REQ_ALLOC, 0, 0));
    issue(mk(REQ_FREE, 5, 0));
    issue(mk(REQ_ALLOC, 12'hFFF, 8191));
    issue(mk(REQ_ALLOC, 0, 4097));
    issue(mk(REQ_ALLOC, 0, 4096));
    issue(mk(REQ_ALLOC, 0, 1));
    issue(mk(REQ_FREE, 4095, 1));
    issue(mk(REQ_FREE, 4095, 2));
    issue(mk(REQ_FREE, 4095, 8191));
    issue(mk(REQ_ALLOC, 0, 1));
    issue(mk(REQ_FREE, 0, 4096));
    issue(mk(REQ_FREE, 0, 4096));
    issue(mk(REQ_ALLOC, 0, 63));
    issue(mk(REQ_ALLOC, 0, 2));
    issue(mk(REQ_ALLOC, 0, 1));
    issue(mk(REQ_FREE, 1, 62));
    issue(mk(REQ_ALLOC, 0, 62));
    issue(mk(REQ_FREE, 0, 66));
    issue(mk(REQ_FREE, 12'hAAA, 1));
    issue(mk(REQ_FREE, 12'h555, 13'h0AAA));
    issue(mk(REQ_ALLOC, 12'h555, 13'h1555));

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_total(phase_total[p]);
      if (p == 0) begin
        // A single-slot map: fill it, overflow it, and free past its end.
        issue(mk(REQ_ALLOC, 0, 1));
        issue(mk(REQ_ALLOC, 0, 1));
        issue(mk(REQ_FREE, 0, 2));
        issue(mk(REQ_FREE, 0, 1));
        issue(mk(REQ_FREE, 1, 1));
      end
      for (int k = 0; k < phase_items[p]; k++) begin
        issue(pick_item());
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
